// ===== src/pedc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_pkg
// Shared types and constants for the encoder drive PID controller.
// ----------------------------------------------------------------------------
package pedc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  // accumulator / multiplicand and multiplier widths of the shared shift-add unit, integral and error widths
  localparam int ACC_W  = 82;
  localparam int MPL_W  = 21;
  localparam int INT_W  = 48;
  localparam int ERR_W  = 34;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_ROTATE = 3'd4;
  localparam logic [2:0] REG_MARGIN = 3'd5;

  localparam logic [7:0] MARGIN_RST = 8'd3;
  localparam logic [7:0] OUT_LIMIT  = 8'd254;

  // multiplier operand lengths (bits iterated, sign bit included)
  localparam logic [4:0] LEN_GAIN = 5'd16;
  localparam logic [4:0] LEN_MS   = 5'd17;
  localparam logic [4:0] LEN_K1   = 5'd11;
  localparam logic [4:0] LEN_K2   = 5'd21;

  localparam logic [MPL_W-1:0] K_THOUSAND = 21'd1000;
  localparam logic [MPL_W-1:0] K_MILLION  = 21'd1000000;

  localparam logic signed [INT_W+2:0] INT_MAX = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [INT_W+2:0] INT_MIN = -51'sh0_7FFF_FFFF_FFFF - 51'sd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEAS, ST_ERR, ST_CHK, ST_IMUL, ST_ISUM,
    ST_GD, ST_K2, ST_GP, ST_K1, ST_GI, ST_TM,
    ST_NABS, ST_DCHK, ST_DIV, ST_FIN
  } state_t;

endpackage

// ===== src/pid_encoder_drive_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_encoder_drive_controller
// PID position loop for a two-motor encoder drive, one shared shift-add unit.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_     | in  | tdata: count_a, count_b, elapsed_ms; tuser: restart
//  out_    | out | tdata: pwm_a, dir_a_fwd, dir_a_rev, pwm_b, dir_b_one,
//          |     |        dir_b_two, done_res
//  cfg_    | in  | write enable, register index, 16-bit data
//
//  A computed tick puts seven products of 11 to 21 bits through one bit-serial
//  multiply-accumulate unit (one bit a cycle), then a 9-step restoring divide
//  unless the quotient saturates. A sign reversal skips the integral product.
//  Zero elapsed time ends after the integral update, a tick within the margin
//  at the margin check, and a tick with done latched straight from idle.
//  in_tready is high only in idle; one finished item waits in the output
//  register while the next is accepted, and a second finished item holds the
//  sequencer until the output register frees. Reset is synchronous.
// ----------------------------------------------------------------------------
module pid_encoder_drive_controller #(
  parameter int COUNT_WIDTH = pedc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // count_a[31:0], count_b[63:32], elapsed_ms[79:64]
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pwm_a, dir_a_fwd, dir_a_rev, pwm_b, dir_b_one,
                                  // dir_b_two, done_res, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pedc_pkg::*;

  localparam int SH = 32 - COUNT_WIDTH;

  state_t state_r, state_nxt;

  logic signed [15:0] target_r, gp_r, gi_r, gd_r;
  logic               rot_r;
  logic [7:0]         margin_r;

  logic signed [31:0]      a_r, a_nxt, b_r, b_nxt;
  logic [15:0]             ms_r, ms_nxt;
  logic signed [ERR_W-1:0] meas_r, meas_nxt, e_r, e_nxt, pe_r, pe_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic                    fin_r, fin_nxt;

  logic signed [ACC_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt, hold_r, hold_nxt;
  logic signed [MPL_W-1:0] mplier_r, mplier_nxt;
  logic [4:0]              cnt_r, cnt_nxt, len_r, len_nxt;

  logic [ACC_W-1:0] nmag_r, nmag_nxt;
  logic             nneg_r, nneg_nxt;
  logic [25:0]      den_r, den_nxt;
  logic [34:0]      rem_r, rem_nxt, dv_r, dv_nxt;
  logic [8:0]       q_r, q_nxt;
  logic [3:0]       dcnt_r, dcnt_nxt;

  logic [7:0] res_mag_r, res_mag_nxt;
  logic       res_neg_r, res_neg_nxt, res_done_r, res_done_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // combinational helpers
  logic signed [31:0]      a_in, b_in;
  logic signed [32:0]      sum_ab, sum_adj, diff_ab;
  logic [32:0]             absdiff;
  logic [ERR_W-1:0]        e_mag;
  logic                    reversal;
  logic signed [ERR_W:0]   de;
  logic signed [INT_W+2:0] isum;
  logic signed [ACC_W-1:0] addend, acc_step;
  logic                    mac_last;
  logic                    a_neg, nz;

  assign a_in = $signed(in_tdata[31:0] << SH) >>> SH;
  assign b_in = $signed(in_tdata[63:32] << SH) >>> SH;

  assign sum_ab  = {a_r[31], a_r} + {b_r[31], b_r};
  assign sum_adj = sum_ab + {32'b0, sum_ab[32]};
  assign diff_ab = {a_r[31], a_r} - {b_r[31], b_r};
  assign absdiff = diff_ab[32] ? 33'(-diff_ab) : 33'(diff_ab);

  assign e_mag    = e_r[ERR_W-1] ? ERR_W'(-e_r) : ERR_W'(e_r);
  assign reversal = (e_r < 0 && pe_r > 0) || (e_r > 0 && pe_r < 0);
  assign de       = {e_r[ERR_W-1], e_r} - {pe_r[ERR_W-1], pe_r};
  assign isum     = {{3{integ_r[INT_W-1]}}, integ_r} + acc_r[INT_W+2:0];

  // shared bit-serial multiply-accumulate step (sign bit weighs negative)
  assign addend   = mplier_r[0] ? mcand_r : '0;
  assign mac_last = (cnt_r == len_r - 5'd1);
  assign acc_step = mac_last ? acc_r - addend : acc_r + addend;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      gp_r     <= '0;
      gi_r     <= '0;
      gd_r     <= '0;
      rot_r    <= 1'b0;
      margin_r <= MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: target_r <= cfg_wdata;
        REG_GAIN_P: gp_r     <= cfg_wdata;
        REG_GAIN_I: gi_r     <= cfg_wdata;
        REG_GAIN_D: gd_r     <= cfg_wdata;
        REG_ROTATE: rot_r    <= cfg_wdata[0];
        REG_MARGIN: margin_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
      integ_r     <= '0;
      pe_r        <= '0;
      nneg_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
      integ_r     <= integ_nxt;
      pe_r        <= pe_nxt;
      nneg_r      <= nneg_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ms_r       <= ms_nxt;
    meas_r     <= meas_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    hold_r     <= hold_nxt;
    mplier_r   <= mplier_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    nmag_r     <= nmag_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    res_mag_r  <= res_mag_nxt;
    res_neg_r  <= res_neg_nxt;
    res_done_r <= res_done_nxt;
    out_data_r <= out_data_nxt;
  end

  // output mapping of the finished command
  assign nz    = (res_mag_r != 8'd0);
  assign a_neg = rot_r ? ~res_neg_r : res_neg_r;

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ms_nxt        = ms_r;
    meas_nxt      = meas_r;
    e_nxt         = e_r;
    pe_nxt        = pe_r;
    integ_nxt     = integ_r;
    fin_nxt       = fin_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    hold_nxt      = hold_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    nmag_nxt      = nmag_r;
    nneg_nxt      = nneg_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    res_mag_nxt   = res_mag_r;
    res_neg_nxt   = res_neg_r;
    res_done_nxt  = res_done_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    // running multiply step, overridden below when an operation ends
    if (state_r == ST_IMUL || state_r == ST_GD || state_r == ST_K2 ||
        state_r == ST_GP || state_r == ST_K1 || state_r == ST_GI ||
        state_r == ST_TM) begin
      acc_nxt    = acc_step;
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >>> 1;
      cnt_nxt    = cnt_r + 5'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt  = a_in;
          b_nxt  = b_in;
          ms_nxt = in_tdata[79:64];
          if (in_tuser) begin
            integ_nxt = '0;
            pe_nxt    = '0;
          end
          fin_nxt = fin_r && !in_tuser;
          if (fin_r && !in_tuser) begin
            res_mag_nxt  = 8'd0;
            res_neg_nxt  = 1'b0;
            res_done_nxt = 1'b1;
            state_nxt    = ST_FIN;
            q_nxt        = 9'd0;
          end else begin
            state_nxt = ST_MEAS;
          end
        end
      end

      ST_MEAS: begin
        meas_nxt  = rot_r ? $signed({1'b0, absdiff})
                          : $signed({{2{sum_adj[32]}}, sum_adj[32:1]});
        state_nxt = ST_ERR;
      end

      ST_ERR: begin
        e_nxt     = meas_r - {{(ERR_W-16){target_r[15]}}, target_r};
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (e_mag <= {{(ERR_W-8){1'b0}}, margin_r}) begin
          fin_nxt      = 1'b1;
          res_done_nxt = 1'b1;
          q_nxt        = 9'd0;
          state_nxt    = ST_FIN;
        end else if (reversal) begin
          integ_nxt = '0;
          state_nxt = ST_ISUM;
          acc_nxt   = '0;
        end else begin
          acc_nxt    = '0;
          mcand_nxt  = {{(ACC_W-ERR_W){e_r[ERR_W-1]}}, e_r};
          mplier_nxt = $signed({5'b0, ms_r});
          cnt_nxt    = '0;
          len_nxt    = LEN_MS;
          state_nxt  = ST_IMUL;
        end
      end

      ST_IMUL: begin
        if (mac_last) state_nxt = ST_ISUM;
      end

      // saturating integral update (after a reversal acc is zero, integ zero)
      ST_ISUM: begin
        if (isum > INT_MAX)      integ_nxt = INT_MAX[INT_W-1:0];
        else if (isum < INT_MIN) integ_nxt = INT_MIN[INT_W-1:0];
        else                     integ_nxt = isum[INT_W-1:0];
        if (ms_r == 16'd0) begin
          res_done_nxt = 1'b0;
          q_nxt        = 9'd0;
          state_nxt    = ST_FIN;
        end else begin
          acc_nxt    = '0;
          mcand_nxt  = {{(ACC_W-ERR_W-1){de[ERR_W]}}, de};
          mplier_nxt = $signed({{(MPL_W-16){gd_r[15]}}, gd_r});
          cnt_nxt    = '0;
          len_nxt    = LEN_GAIN;
          state_nxt  = ST_GD;
        end
      end

      ST_GD: begin
        if (mac_last) begin
          mcand_nxt  = acc_step;
          acc_nxt    = '0;
          mplier_nxt = K_MILLION;
          cnt_nxt    = '0;
          len_nxt    = LEN_K2;
          state_nxt  = ST_K2;
        end
      end

      ST_K2: begin
        if (mac_last) begin
          hold_nxt   = acc_step;
          acc_nxt    = '0;
          mcand_nxt  = {{(ACC_W-ERR_W){e_r[ERR_W-1]}}, e_r};
          mplier_nxt = $signed({{(MPL_W-16){gp_r[15]}}, gp_r});
          cnt_nxt    = '0;
          len_nxt    = LEN_GAIN;
          state_nxt  = ST_GP;
        end
      end

      ST_GP: begin
        if (mac_last) begin
          mcand_nxt  = acc_step;
          acc_nxt    = '0;
          mplier_nxt = K_THOUSAND;
          cnt_nxt    = '0;
          len_nxt    = LEN_K1;
          state_nxt  = ST_K1;
        end
      end

      ST_K1: begin
        if (mac_last) begin
          acc_nxt    = acc_step;
          mcand_nxt  = {{(ACC_W-INT_W){integ_r[INT_W-1]}}, integ_r};
          mplier_nxt = $signed({{(MPL_W-16){gi_r[15]}}, gi_r});
          cnt_nxt    = '0;
          len_nxt    = LEN_GAIN;
          state_nxt  = ST_GI;
        end
      end

      ST_GI: begin
        if (mac_last) begin
          mcand_nxt  = acc_step;
          acc_nxt    = hold_r;
          mplier_nxt = $signed({5'b0, ms_r});
          cnt_nxt    = '0;
          len_nxt    = LEN_MS;
          state_nxt  = ST_TM;
        end
      end

      ST_TM: begin
        if (mac_last) state_nxt = ST_NABS;
      end

      // numerator magnitude and divisor ms*1000
      ST_NABS: begin
        nmag_nxt  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        nneg_nxt  = acc_r[ACC_W-1];
        den_nxt   = {ms_r, 10'b0} - {6'b0, ms_r, 4'b0} - {7'b0, ms_r, 3'b0};
        pe_nxt    = e_r;
        state_nxt = ST_DCHK;
      end

      ST_DCHK: begin
        res_done_nxt = 1'b0;
        if (nmag_r >= {{(ACC_W-35){1'b0}}, den_r, 9'b0}) begin
          q_nxt     = 9'h1FF;
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = nmag_r[34:0];
          dv_nxt    = {1'b0, den_r, 8'b0};
          q_nxt     = 9'd0;
          dcnt_nxt  = 4'd0;
          state_nxt = ST_DIV;
        end
      end

      // restoring divide, one quotient bit a cycle
      ST_DIV: begin
        if (rem_r >= dv_r) begin
          rem_nxt = rem_r - dv_r;
          q_nxt   = {q_r[7:0], 1'b1};
        end else begin
          q_nxt   = {q_r[7:0], 1'b0};
        end
        dv_nxt   = dv_r >> 1;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd8) state_nxt = ST_FIN;
      end

      // clamp, then hand over to the output register when it is free
      ST_FIN: begin
        res_mag_nxt = (q_r > {1'b0, OUT_LIMIT}) ? OUT_LIMIT : q_r[7:0];
        res_neg_nxt = nneg_r;
        if (res_done_r || q_r == 9'd0) res_mag_nxt = 8'd0;
        if (res_mag_r == res_mag_nxt && res_neg_r == res_neg_nxt &&
            (!out_valid_r || out_tready)) begin
          out_data_nxt  = {3'b0, res_done_r,
                           nz & ~res_neg_r, nz & res_neg_r, res_mag_r,
                           nz & a_neg, nz & ~a_neg, res_mag_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
